// File: hw/rtl/cbdq_pkg.sv
package cbdq_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ_INDEX = 3'd4,
    REQ_CLEAR      = 3'd5
  } cbdq_req_code_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2,
    ST_RANGE     = 2'd3
  } cbdq_status_t;

  typedef enum logic [1:0] {
    D_HOLD,
    D_FROM_LEFT,
    D_FROM_RIGHT,
    D_WRITE_AT
  } cbdq_data_op_t;

  typedef enum logic [1:0] {
    T_HOLD,
    T_LOAD,
    T_SHIFT
  } cbdq_tap_op_t;

  typedef struct packed {
    cbdq_data_op_t data_op;
    cbdq_tap_op_t  tap_op;
  } cbdq_ctl_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] value;
    logic [15:0] position;
  } cbdq_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] front_value;
    logic [31:0] back_value;
    logic [4:0]  count;
    logic        is_empty;
    logic        is_full;
    logic [1:0]  status;
  } cbdq_rsp_t;

endpackage

// File: hw/rtl/cbdq_if.sv
interface cbdq_in_if;
  logic                valid;
  logic                ready;
  cbdq_pkg::cbdq_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cbdq_out_if;
  logic                valid;
  logic                ready;
  cbdq_pkg::cbdq_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/cbdq_cell.sv
module cbdq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cbdq_pkg::cbdq_ctl_t   ctl,
  input  logic [CNT_W-1:0]      count,
  input  logic [DATA_WIDTH-1:0] push_word,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic [DATA_WIDTH-1:0] right_tap,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] tap_o
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic [DATA_WIDTH-1:0] tap_r;
  logic [DATA_WIDTH-1:0] tap_nxt;

  always_comb begin
    case (ctl.data_op)
      cbdq_pkg::D_HOLD:       data_nxt = data_r;
      cbdq_pkg::D_FROM_LEFT:  data_nxt = left_data;
      cbdq_pkg::D_FROM_RIGHT: data_nxt = right_data;
      cbdq_pkg::D_WRITE_AT:   data_nxt = (count == CNT_W'(IDX)) ? push_word : data_r;
      default:                data_nxt = data_r;
    endcase
  end

  always_comb begin
    case (ctl.tap_op)
      cbdq_pkg::T_HOLD:  tap_nxt = tap_r;
      cbdq_pkg::T_LOAD:  tap_nxt = data_r;
      cbdq_pkg::T_SHIFT: tap_nxt = right_tap;
      default:           tap_nxt = tap_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    tap_r  <= tap_nxt;
  end

  assign data_o = data_r;
  assign tap_o  = tap_r;

endmodule

// File: hw/rtl/circular_buffer_deque_unit.sv
// Double-ended queue of DEPTH words held in a row of cells, cell 0 at the head.
// in_ch carries one request word (req_type, value, position); out_ch returns
// one result word per request: read data, front and back values, count,
// empty and full flags and status.
// A push at the front shifts every cell one place back; a pop at the front
// shifts every cell one place forward; a push at the back writes the cell at
// the count; a pop at the back or a clear only moves the count.
// The pointer/count update happens at the accept edge. A tap lane in the cells
// is then loaded and walked toward cell 0 one place a cycle, which yields the
// indexed read and the back value.
// One request is in work at a time: no new request is taken until the result
// of the last one has been placed in the output register.
// in_ch.ready is high when no request is in work; a finished result sits in
// the output register and the next request is taken while it waits. When the
// receiver stalls, a second finished result holds until the first is taken.
// Synchronous active-low reset empties the queue and drops any result.
module circular_buffer_deque_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  cbdq_in_if.sink           in_ch,
  cbdq_out_if.source        out_ch
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOAD,
    S_WALK,
    S_HOLD
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             count_nxt;
  logic [CNT_W-1:0]             step_r;
  logic [15:0]                  pos_r;
  logic                         rd_en_r;
  cbdq_pkg::cbdq_status_t       st_r;
  cbdq_pkg::cbdq_status_t       st_nxt;
  logic                         rd_en_nxt;
  logic [DATA_WIDTH-1:0]        rd_r;
  logic [DATA_WIDTH-1:0]        front_r;
  logic [DATA_WIDTH-1:0]        back_r;
  logic                         out_valid_r;
  cbdq_pkg::cbdq_rsp_t          out_data_r;

  cbdq_pkg::cbdq_ctl_t          ctl;
  logic [DATA_WIDTH-1:0]        push_word;
  logic [DATA_WIDTH-1:0]        data_w [DEPTH];
  logic [DATA_WIDTH-1:0]        tap_w  [DEPTH];

  logic                         accept;
  logic                         full;
  logic                         empty;
  logic                         last_step;
  logic                         slot_free;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign push_word    = DATA_WIDTH'(in_ch.data.value);
  assign full         = (count_r == CNT_W'(DEPTH));
  assign empty        = (count_r == '0);
  assign last_step    = (step_r == count_r - CNT_W'(1));
  assign slot_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    count_nxt    = count_r;
    st_nxt       = cbdq_pkg::ST_OK;
    rd_en_nxt    = 1'b0;
    ctl.data_op  = cbdq_pkg::D_HOLD;
    ctl.tap_op   = cbdq_pkg::T_HOLD;
    if (accept) begin
      case (cbdq_pkg::cbdq_req_code_t'(in_ch.data.req_type))
        cbdq_pkg::REQ_PUSH_BACK: begin
          if (full) begin
            st_nxt = cbdq_pkg::ST_PUSH_FULL;
          end else begin
            ctl.data_op = cbdq_pkg::D_WRITE_AT;
            count_nxt   = count_r + CNT_W'(1);
          end
        end
        cbdq_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            st_nxt = cbdq_pkg::ST_PUSH_FULL;
          end else begin
            ctl.data_op = cbdq_pkg::D_FROM_LEFT;
            count_nxt   = count_r + CNT_W'(1);
          end
        end
        cbdq_pkg::REQ_POP_BACK: begin
          if (empty) begin
            st_nxt = cbdq_pkg::ST_POP_EMPTY;
          end else begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
        cbdq_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            st_nxt = cbdq_pkg::ST_POP_EMPTY;
          end else begin
            ctl.data_op = cbdq_pkg::D_FROM_RIGHT;
            count_nxt   = count_r - CNT_W'(1);
          end
        end
        cbdq_pkg::REQ_READ_INDEX: begin
          if (CMP_W'(in_ch.data.position) >= CMP_W'(count_r)) begin
            st_nxt = cbdq_pkg::ST_RANGE;
          end else begin
            rd_en_nxt = 1'b1;
          end
        end
        cbdq_pkg::REQ_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
    if (state_r == S_LOAD) begin
      ctl.tap_op = cbdq_pkg::T_LOAD;
    end else if (state_r == S_WALK) begin
      ctl.tap_op = cbdq_pkg::T_SHIFT;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    logic [DATA_WIDTH-1:0] right_t;
    if (i == 0) begin : g_head
      assign left_d = push_word;
    end else begin : g_mid_l
      assign left_d = data_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_d = data_w[i];
      assign right_t = tap_w[i];
    end else begin : g_mid_r
      assign right_d = data_w[i+1];
      assign right_t = tap_w[i+1];
    end
    cbdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .count      (count_r),
      .push_word  (push_word),
      .left_data  (left_d),
      .right_data (right_d),
      .right_tap  (right_t),
      .data_o     (data_w[i]),
      .tap_o      (tap_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      st_r        <= cbdq_pkg::ST_OK;
      rd_en_r     <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_valid_r && out_ch.ready && (state_r != S_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            st_r    <= st_nxt;
            rd_en_r <= rd_en_nxt;
            pos_r   <= in_ch.data.position;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          step_r  <= '0;
          rd_r    <= '0;
          front_r <= '0;
          back_r  <= '0;
          state_r <= empty ? S_HOLD : S_WALK;
        end
        S_WALK: begin
          if (step_r == '0) begin
            front_r <= tap_w[0];
          end
          if (rd_en_r && (CMP_W'(step_r) == CMP_W'(pos_r))) begin
            rd_r <= tap_w[0];
          end
          if (last_step) begin
            back_r  <= tap_w[0];
            state_r <= S_HOLD;
          end else begin
            step_r <= step_r + CNT_W'(1);
          end
        end
        S_HOLD: begin
          if (slot_free) begin
            out_valid_r            <= 1'b1;
            out_data_r.read_data   <= 32'(rd_r);
            out_data_r.front_value <= 32'(front_r);
            out_data_r.back_value  <= 32'(back_r);
            out_data_r.count       <= 5'(count_r);
            out_data_r.is_empty    <= empty;
            out_data_r.is_full     <= full;
            out_data_r.status      <= st_r;
            state_r                <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_full_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (in_ch.data.req_type == cbdq_pkg::REQ_PUSH_BACK ||
                        in_ch.data.req_type == cbdq_pkg::REQ_PUSH_FRONT))
    |=> $stable(count_r))
    else $error("push on full changed the count");

  a_pop_front_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !empty && in_ch.data.req_type == cbdq_pkg::REQ_POP_FRONT)
    |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("pop front did not decrement the count");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (step_r < count_r))
    else $error("tap walk ran past the live elements");

  a_hold_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HOLD && !slot_free) |=> (state_r == S_HOLD && out_valid_r))
    else $error("result lost while the receiver stalls");

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 500000;
  localparam int TAIL_CYCLES = 40;

  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst_n;

  cbdq_in_if  in_ch();
  cbdq_out_if out_ch();

  circular_buffer_deque_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (32)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [31:0] dq_store [DEPTH];
  logic [3:0]  dq_head;
  logic [3:0]  dq_tail;
  logic [4:0]  dq_count;

  cbdq_pkg::cbdq_rsp_t rsp_expected [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int send_idle_pct  = 0;
  int rsp_stall_pct  = 0;
  int holdoff_left   = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic cbdq_pkg::cbdq_rsp_t deque_apply(input cbdq_pkg::cbdq_req_t r);
    cbdq_pkg::cbdq_rsp_t o;
    logic [3:0]          slot;
    o = '0;
    case (r.req_type)
      cbdq_pkg::REQ_PUSH_BACK: begin
        if (dq_count == DEPTH) begin
          o.status = cbdq_pkg::ST_PUSH_FULL;
        end else begin
          dq_tail = dq_tail + 4'd1;
          dq_store[dq_tail] = r.value;
          dq_count++;
        end
      end
      cbdq_pkg::REQ_PUSH_FRONT: begin
        if (dq_count == DEPTH) begin
          o.status = cbdq_pkg::ST_PUSH_FULL;
        end else begin
          dq_head = dq_head - 4'd1;
          dq_store[dq_head] = r.value;
          dq_count++;
        end
      end
      cbdq_pkg::REQ_POP_BACK: begin
        if (dq_count == 0) begin
          o.status = cbdq_pkg::ST_POP_EMPTY;
        end else begin
          dq_tail = dq_tail - 4'd1;
          dq_count--;
        end
      end
      cbdq_pkg::REQ_POP_FRONT: begin
        if (dq_count == 0) begin
          o.status = cbdq_pkg::ST_POP_EMPTY;
        end else begin
          dq_head = dq_head + 4'd1;
          dq_count--;
        end
      end
      cbdq_pkg::REQ_READ_INDEX: begin
        if (r.position >= dq_count) begin
          o.status = cbdq_pkg::ST_RANGE;
        end else begin
          slot = dq_head + r.position[3:0];
          o.read_data = dq_store[slot];
        end
      end
      cbdq_pkg::REQ_CLEAR: begin
        dq_head  = 4'd0;
        dq_tail  = 4'(DEPTH - 1);
        dq_count = 5'd0;
      end
      default: ;
    endcase
    o.front_value = (dq_count != 0) ? dq_store[dq_head] : 32'd0;
    o.back_value  = (dq_count != 0) ? dq_store[dq_tail] : 32'd0;
    o.count       = dq_count;
    o.is_empty    = (dq_count == 0);
    o.is_full     = (dq_count == DEPTH);
    return o;
  endfunction

  function automatic cbdq_pkg::cbdq_req_t mk_req(input logic [2:0] code,
                                                 input logic [31:0] value,
                                                 input logic [15:0] position);
    cbdq_pkg::cbdq_req_t r;
    r.req_type = code;
    r.value    = value;
    r.position = position;
    return r;
  endfunction

  // pick a request, push share set by fill_pct, positions mostly within 0 to count + 1
  function automatic cbdq_pkg::cbdq_req_t pick_req(input int fill_pct);
    cbdq_pkg::cbdq_req_t r;
    int                  roll;
    roll = $urandom_range(99);
    r.value    = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'd0)
                                          : 32'($urandom);
    r.position = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(dq_count + 1));
    if (roll < fill_pct) begin
      r.req_type = $urandom_range(1) ? cbdq_pkg::REQ_PUSH_BACK : cbdq_pkg::REQ_PUSH_FRONT;
    end else if (roll < 80) begin
      r.req_type = $urandom_range(1) ? cbdq_pkg::REQ_POP_BACK : cbdq_pkg::REQ_POP_FRONT;
    end else if (roll < 97) begin
      r.req_type = cbdq_pkg::REQ_READ_INDEX;
    end else if (roll < 98) begin
      r.req_type = cbdq_pkg::REQ_CLEAR;
    end else begin
      r.req_type = $urandom_range(1) ? REQ_SPARE_6 : REQ_SPARE_7;
    end
    return r;
  endfunction

  task automatic send_req(input cbdq_pkg::cbdq_req_t r);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= r;
    do @(posedge clk); while (!in_ch.ready);
    rsp_expected = {rsp_expected, deque_apply(r)};
  endtask

  task automatic sender_rest();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_all_results();
    sender_rest();
    while (rsp_expected.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_left > 0) begin
        holdoff_left = holdoff_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cbdq_pkg::cbdq_rsp_t got;
    cbdq_pkg::cbdq_rsp_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (rsp_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result word %h", got));
      end else begin
        exp = rsp_expected[0];
        rsp_expected.delete(0);
        if (got.read_data !== exp.read_data)
          report_mismatch($sformatf("read_data got %h exp %h", got.read_data, exp.read_data));
        if (got.front_value !== exp.front_value)
          report_mismatch($sformatf("front_value got %h exp %h",
                                    got.front_value, exp.front_value));
        if (got.back_value !== exp.back_value)
          report_mismatch($sformatf("back_value got %h exp %h", got.back_value, exp.back_value));
        if (got.count !== exp.count)
          report_mismatch($sformatf("count got %0d exp %0d", got.count, exp.count));
        if (got.is_empty !== exp.is_empty)
          report_mismatch($sformatf("is_empty got %b exp %b", got.is_empty, exp.is_empty));
        if (got.is_full !== exp.is_full)
          report_mismatch($sformatf("is_full got %b exp %b", got.is_full, exp.is_full));
        if (got.status !== exp.status)
          report_mismatch($sformatf("status got %0d exp %0d", got.status, exp.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_edge_requests();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    send_req(mk_req(cbdq_pkg::REQ_POP_BACK,   32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_POP_FRONT,  32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0,        16'hFFFF));
    send_req(mk_req(cbdq_pkg::REQ_CLEAR,      32'd0,        16'd0));
    send_req(mk_req(REQ_SPARE_6,              32'hFFFF_FFFF, 16'hFFFF));
    send_req(mk_req(REQ_SPARE_7,              32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_PUSH_BACK,  32'hFFFF_FFFF, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0,        16'd1));
    send_req(mk_req(cbdq_pkg::REQ_POP_FRONT,  32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_PUSH_FRONT, 32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_PUSH_BACK,  32'h5A5A_A5A5, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_PUSH_FRONT, 32'h8000_0001, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0,        16'd2));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0,        16'd3));
    send_req(mk_req(cbdq_pkg::REQ_POP_BACK,   32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_POP_BACK,   32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_POP_BACK,   32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_PUSH_BACK,  32'h0000_0001, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_CLEAR,      32'd0,        16'd0));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0,        16'd0));
  endtask

  task automatic test_fill_to_full();
    send_req(mk_req(cbdq_pkg::REQ_CLEAR, 32'd0, 16'd0));
    repeat (DEPTH)
      send_req(mk_req($urandom_range(1) ? cbdq_pkg::REQ_PUSH_BACK : cbdq_pkg::REQ_PUSH_FRONT,
                      $urandom, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_PUSH_BACK,  $urandom, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_PUSH_FRONT, $urandom, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0, 16'(DEPTH - 1)));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0, 16'(DEPTH)));
    send_req(mk_req(cbdq_pkg::REQ_READ_INDEX, 32'd0, 16'hFFFF));
    repeat (DEPTH)
      send_req(mk_req($urandom_range(1) ? cbdq_pkg::REQ_POP_BACK : cbdq_pkg::REQ_POP_FRONT,
                      32'd0, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_POP_FRONT, 32'd0, 16'd0));
    send_req(mk_req(cbdq_pkg::REQ_POP_BACK,  32'd0, 16'd0));
  endtask

  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++)
      send_req(pick_req(((i / 32) % 2) ? 25 : 65));
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    holdoff_left  = 300;
    for (int i = 0; i < 40; i++)
      send_req(pick_req(65));
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 20;
    rsp_stall_pct = 20;
    for (int i = 0; i < 20; i++)
      send_req(pick_req(50));
    wait_all_results();
    for (int i = 0; i < 20; i++)
      send_req(pick_req(50));
  endtask

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    dq_head     = 4'd0;
    dq_tail     = 4'(DEPTH - 1);
    dq_count    = 5'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_requests();
    test_fill_to_full();
    test_random_traffic(180, 0, 0);
    test_random_traffic(130, 88, 0);
    test_random_traffic(130, 0, 88);
    test_random_traffic(130, 20, 20);
    test_output_holdoff();
    test_drain_pause();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && rsp_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
